### hdl/cmfr_pkg.sv
package cmfr_pkg;

   localparam int ACT_W    = 2;
   localparam int ID_W     = 29;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int RADDR_W  = 7;
   localparam int RES_W    = 3;
   localparam int PLEN_W   = 11;
   localparam int SUM_W    = 32;
   localparam int KIND_W   = 2;
   localparam int KIND_LSB = 23;
   localparam int SEQ_W    = 4;
   localparam int SEQ_LSB  = 19;
   localparam int BYTES    = 8;
   localparam int BSUM_W   = 11;

   typedef enum logic [ACT_W-1:0] {
      ACT_FRAME,
      ACT_TAKE,
      ACT_READ,
      ACT_NONE
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRST,
      KIND_MIDDLE,
      KIND_VERIFY,
      KIND_SINGLE
   } kind_type;

   typedef enum logic [RES_W-1:0] {
      RES_NONE,
      RES_STARTED,
      RES_STORED,
      RES_ERROR,
      RES_CHECK_OK,
      RES_CHECK_FAIL,
      RES_SINGLE
   } frame_res_type;

endpackage

### hdl/cmfr_ram.sv
module cmfr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/can_multiframe_reassembler_core.sv
// Channel  | Ports                                         | Transaction
// request  | req_valid/req_ready, action, id, len, data,   | one action: frame, take or read
//          | read_addr                                     |
// response | rsp_valid/rsp_ready, frame_result, pack_*,    | one result for each request
//          | read_data                                     |
//
// First frame and rejected middle frame: clear sweep of the store (one word a cycle), then the result.
// Verify frame: the stored words are summed (one word summed per cycle), then the last store read
// is drained. Middle and single frames: read-modify-write of one store word.
// Take, unused action, verify without a transfer, read out of range: straight to the result; read: store read first.
// After reset the store is cleared, one word a cycle, with req_ready low.
// A finished result waits in the response register; the next request is taken meanwhile.
module can_multiframe_reassembler_core #(
   parameter int STORE_WORDS = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cmfr_pkg::ACT_W-1:0]    req_action,
   input  logic [cmfr_pkg::ID_W-1:0]     req_frame_id,
   input  logic [cmfr_pkg::LEN_W-1:0]    req_data_len,
   input  logic [cmfr_pkg::DATA_W-1:0]   req_frame_data,
   input  logic [cmfr_pkg::RADDR_W-1:0]  req_read_addr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cmfr_pkg::RES_W-1:0]    rsp_frame_result,
   output logic                          rsp_pack_ready,
   output logic [cmfr_pkg::ID_W-1:0]     rsp_pack_id,
   output logic [cmfr_pkg::PLEN_W-1:0]   rsp_pack_len,
   output logic [cmfr_pkg::DATA_W-1:0]   rsp_read_data
);

   localparam int AW = $clog2(STORE_WORDS);
   localparam int CW = $clog2(STORE_WORDS + 1);
   localparam int LW = $clog2(8 * STORE_WORDS + 9);
   localparam int NB = cmfr_pkg::BYTES;
   localparam int DW = cmfr_pkg::DATA_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_READ,
      ST_READ_DATA,
      ST_SUM,
      ST_EMIT
   } state_type;

   state_type                      state_ff, state_in;
   logic                           clr_emit_ff, clr_emit_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [LW-1:0]                  rem_ff, rem_in;
   logic                           pend_ff, pend_in;
   logic [cmfr_pkg::LEN_W-1:0]     pbytes_ff, pbytes_in;
   logic [cmfr_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [cmfr_pkg::SUM_W-1:0]     expected_ff, expected_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic                           xfer_ff, xfer_in;
   logic                           ready_ff, ready_in;
   logic [cmfr_pkg::ID_W-1:0]      sid_ff, sid_in;
   logic [LW-1:0]                  slen_ff, slen_in;
   logic [cmfr_pkg::ID_W-1:0]      id_ff, id_in;
   logic [DW-1:0]                  mask_ff, mask_in;
   logic [DW-1:0]                  data_ff, data_in;
   logic [AW-1:0]                  waddr_ff, waddr_in;
   cmfr_pkg::frame_res_type        res_result_ff, res_result_in;
   logic                           res_pready_ff, res_pready_in;
   logic [cmfr_pkg::ID_W-1:0]      res_pid_ff, res_pid_in;
   logic [cmfr_pkg::PLEN_W-1:0]    res_plen_ff, res_plen_in;
   logic [DW-1:0]                  res_rdata_ff, res_rdata_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cmfr_pkg::RES_W-1:0]     rsp_result_ff, rsp_result_in;
   logic                           rsp_pready_ff, rsp_pready_in;
   logic [cmfr_pkg::ID_W-1:0]      rsp_pid_ff, rsp_pid_in;
   logic [cmfr_pkg::PLEN_W-1:0]    rsp_plen_ff, rsp_plen_in;
   logic [DW-1:0]                  rsp_rdata_ff, rsp_rdata_in;

   logic [AW-1:0]                  ram_addr;
   logic                           ram_we;
   logic [DW-1:0]                  ram_wdata;
   logic [DW-1:0]                  ram_rdata;

   logic [cmfr_pkg::LEN_W-1:0]     len_clamp;
   logic [DW-1:0]                  req_mask;
   logic [DW-1:0]                  req_mdata;
   cmfr_pkg::kind_type             req_kind;
   logic [cmfr_pkg::SEQ_W-1:0]     req_seq;
   logic [31:0]                    cnt32;
   logic                           mid_ok;
   logic                           rd_in_range;
   logic [LW-1:0]                  slen_cap;
   logic                           sum_issue;
   logic [cmfr_pkg::LEN_W-1:0]     sum_bytes;
   logic [cmfr_pkg::BSUM_W-1:0]    word_sum;
   logic [cmfr_pkg::ID_W-1:0]      sid_single;

   cmfr_ram #(
      .WIDTH (DW),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign len_clamp = (req_data_len > cmfr_pkg::LEN_W'(NB)) ? cmfr_pkg::LEN_W'(NB) : req_data_len;

   always_comb begin
      for (int b = 0; b < NB; b++) begin
         req_mask[8*b +: 8] = (cmfr_pkg::LEN_W'(b) < len_clamp) ? 8'hFF : 8'h00;
      end
   end

   assign req_mdata   = req_frame_data & req_mask;
   assign req_kind    = cmfr_pkg::kind_type'(req_frame_id[cmfr_pkg::KIND_LSB +: cmfr_pkg::KIND_W]);
   assign req_seq     = req_frame_id[cmfr_pkg::SEQ_LSB +: cmfr_pkg::SEQ_W];
   assign cnt32       = 32'(cnt_ff);
   assign mid_ok      = xfer_ff && (cnt32 < expected_ff) && (cnt32 < 32'(STORE_WORDS)) &&
                        (req_seq == cnt32[cmfr_pkg::SEQ_W-1:0]);
   assign rd_in_range = 32'(req_read_addr) < 32'(STORE_WORDS);
   assign slen_cap    = (slen_ff > LW'(8 * STORE_WORDS)) ? LW'(8 * STORE_WORDS) : slen_ff;
   assign sum_issue   = (rem_ff != '0);
   assign sum_bytes   = (rem_ff >= LW'(NB)) ? cmfr_pkg::LEN_W'(NB) : rem_ff[cmfr_pkg::LEN_W-1:0];

   always_comb begin
      word_sum = '0;
      for (int b = 0; b < NB; b++) begin
         if (cmfr_pkg::LEN_W'(b) < pbytes_ff) begin
            word_sum = word_sum + cmfr_pkg::BSUM_W'(ram_rdata[8*b +: 8]);
         end
      end
   end

   always_comb begin
      sid_single = id_ff;
      sid_single[cmfr_pkg::KIND_LSB +: cmfr_pkg::KIND_W] = cmfr_pkg::KIND_SINGLE;
   end

   always_comb begin
      state_in      = state_ff;
      clr_emit_in   = clr_emit_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      pbytes_in     = pbytes_ff;
      sum_in        = sum_ff;
      expected_in   = expected_ff;
      cnt_in        = cnt_ff;
      xfer_in       = xfer_ff;
      ready_in      = ready_ff;
      sid_in        = sid_ff;
      slen_in       = slen_ff;
      id_in         = id_ff;
      mask_in       = mask_ff;
      data_in       = data_ff;
      waddr_in      = waddr_ff;
      res_result_in = res_result_ff;
      res_pready_in = res_pready_ff;
      res_pid_in    = res_pid_ff;
      res_plen_in   = res_plen_ff;
      res_rdata_in  = res_rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_pready_in = rsp_pready_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_plen_in   = rsp_plen_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      ram_addr      = idx_ff[AW-1:0];
      ram_we        = 1'b0;
      ram_wdata     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(STORE_WORDS - 1)) begin
               idx_in   = '0;
               state_in = clr_emit_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               id_in         = req_frame_id;
               mask_in       = req_mask;
               data_in       = req_mdata;
               res_result_in = cmfr_pkg::RES_NONE;
               res_pready_in = 1'b0;
               res_pid_in    = '0;
               res_plen_in   = '0;
               res_rdata_in  = '0;
               state_in      = ST_EMIT;
               unique case (cmfr_pkg::action_type'(req_action))
                  cmfr_pkg::ACT_FRAME: begin
                     unique case (req_kind)
                        cmfr_pkg::KIND_FIRST: begin
                           expected_in   = req_mdata[cmfr_pkg::SUM_W-1:0];
                           sid_in        = '0;
                           slen_in       = '0;
                           cnt_in        = '0;
                           xfer_in       = 1'b1;
                           res_result_in = cmfr_pkg::RES_STARTED;
                           idx_in        = '0;
                           clr_emit_in   = 1'b1;
                           state_in      = ST_CLEAR;
                        end
                        cmfr_pkg::KIND_MIDDLE: begin
                           if (mid_ok) begin
                              waddr_in      = cnt_ff[AW-1:0];
                              cnt_in        = cnt_ff + 1'b1;
                              slen_in       = slen_ff + LW'(len_clamp);
                              res_result_in = cmfr_pkg::RES_STORED;
                              state_in      = ST_RMW_RD;
                           end else begin
                              sid_in        = '0;
                              slen_in       = '0;
                              expected_in   = '0;
                              cnt_in        = '0;
                              xfer_in       = 1'b0;
                              res_result_in = cmfr_pkg::RES_ERROR;
                              idx_in        = '0;
                              clr_emit_in   = 1'b1;
                              state_in      = ST_CLEAR;
                           end
                        end
                        cmfr_pkg::KIND_VERIFY: begin
                           if (xfer_ff) begin
                              xfer_in  = 1'b0;
                              rem_in   = slen_cap;
                              idx_in   = '0;
                              pend_in  = 1'b0;
                              sum_in   = '0;
                              state_in = ST_SUM;
                           end
                        end
                        cmfr_pkg::KIND_SINGLE: begin
                           sid_in        = req_frame_id;
                           slen_in       = LW'(len_clamp);
                           ready_in      = 1'b1;
                           res_result_in = cmfr_pkg::RES_SINGLE;
                           waddr_in      = '0;
                           state_in      = ST_RMW_RD;
                        end
                        default: ;
                     endcase
                  end
                  cmfr_pkg::ACT_TAKE: begin
                     if (ready_ff) begin
                        ready_in      = 1'b0;
                        res_pready_in = 1'b1;
                        res_pid_in    = sid_ff;
                        res_plen_in   = cmfr_pkg::PLEN_W'(slen_ff);
                     end
                  end
                  cmfr_pkg::ACT_READ: begin
                     if (rd_in_range) begin
                        waddr_in = AW'(32'(req_read_addr));
                        state_in = ST_READ;
                     end
                  end
                  cmfr_pkg::ACT_NONE: ;
                  default: ;
               endcase
            end
         end
         ST_RMW_RD: begin
            ram_addr = waddr_ff;
            state_in = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            ram_addr  = waddr_ff;
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata & ~mask_ff) | data_ff;
            state_in  = ST_EMIT;
         end
         ST_READ: begin
            ram_addr = waddr_ff;
            state_in = ST_READ_DATA;
         end
         ST_READ_DATA: begin
            res_rdata_in = ram_rdata;
            state_in     = ST_EMIT;
         end
         ST_SUM: begin
            pend_in   = sum_issue;
            pbytes_in = sum_bytes;
            if (sum_issue) begin
               idx_in = idx_ff + 1'b1;
               rem_in = rem_ff - LW'(sum_bytes);
            end
            if (pend_ff) begin
               sum_in = sum_ff + cmfr_pkg::SUM_W'(word_sum);
            end
            if (!sum_issue && !pend_ff) begin
               if (sum_ff == data_ff[cmfr_pkg::SUM_W-1:0]) begin
                  sid_in        = sid_single;
                  ready_in      = 1'b1;
                  res_result_in = cmfr_pkg::RES_CHECK_OK;
               end else begin
                  res_result_in = cmfr_pkg::RES_CHECK_FAIL;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_result_ff;
               rsp_pready_in = res_pready_ff;
               rsp_pid_in    = res_pid_ff;
               rsp_plen_in   = res_plen_ff;
               rsp_rdata_in  = res_rdata_ff;
               clr_emit_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_emit_ff  <= 1'b0;
         idx_ff       <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         expected_ff  <= '0;
         cnt_ff       <= '0;
         xfer_ff      <= 1'b0;
         ready_ff     <= 1'b0;
         sid_ff       <= '0;
         slen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_emit_ff  <= clr_emit_in;
         idx_ff       <= idx_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         expected_ff  <= expected_in;
         cnt_ff       <= cnt_in;
         xfer_ff      <= xfer_in;
         ready_ff     <= ready_in;
         sid_ff       <= sid_in;
         slen_ff      <= slen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pbytes_ff     <= pbytes_in;
      sum_ff        <= sum_in;
      id_ff         <= id_in;
      mask_ff       <= mask_in;
      data_ff       <= data_in;
      waddr_ff      <= waddr_in;
      res_result_ff <= res_result_in;
      res_pready_ff <= res_pready_in;
      res_pid_ff    <= res_pid_in;
      res_plen_ff   <= res_plen_in;
      res_rdata_ff  <= res_rdata_in;
      rsp_result_ff <= rsp_result_in;
      rsp_pready_ff <= rsp_pready_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_plen_ff   <= rsp_plen_in;
      rsp_rdata_ff  <= rsp_rdata_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_result = rsp_result_ff;
   assign rsp_pack_ready   = rsp_pready_ff;
   assign rsp_pack_id      = rsp_pid_ff;
   assign rsp_pack_len     = rsp_plen_ff;
   assign rsp_read_data    = rsp_rdata_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous transaction in progress");

   a_ready_source: assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> (res_result_ff == cmfr_pkg::RES_CHECK_OK ||
                           res_result_ff == cmfr_pkg::RES_SINGLE))
      else $error("packet marked ready without a passing check or single frame");

   a_sum_holds_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> $stable(slen_ff) && $stable(cnt_ff))
      else $error("packet length or frame counter changed during checksum sweep");

endmodule
